// File: rtl/chord_step_size_estimator_unit_macros.svh
// assertion helpers shared by the rtl
`ifndef CHORD_STEP_SIZE_ESTIMATOR_UNIT_MACROS_SVH
`define CHORD_STEP_SIZE_ESTIMATOR_UNIT_MACROS_SVH

// same-cycle implication
`define CSSE_ASSERT_NOW(label, clk_i, rstn_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("csse assertion failed");

// plain invariant
`define CSSE_ASSERT_ALWAYS(label, clk_i, rstn_i, cond) \
	label: assert property (@(posedge clk_i) disable iff (!rstn_i) (cond)) \
		else $error("csse invariant failed");

`endif

// File: rtl/csse_pkg.sv
// ----------------------------------------------------------------------------
// csse_pkg
// shared types and constants of the chord step size estimator
// ----------------------------------------------------------------------------
package csse_pkg;

	localparam int LEN_W = 32;
	localparam int FRAC_W = 16;
	localparam int Q_W = 2 * LEN_W;
	localparam int DIV_STAGES = Q_W;
	localparam int SQRT_STAGES = LEN_W;
	localparam int POST_STAGES = 4;
	// entry register + divider + root + post stages
	localparam int PIPE_LAT = 1 + DIV_STAGES + SQRT_STAGES + POST_STAGES;

	localparam logic [LEN_W-1:0] TOL_RESET = LEN_W'(16384);
	localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(64225);

	// floor(x/10) = (x * RECIP10) >> 35, floor(x/25) = (x * RECIP25) >> 35
	localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;
	localparam logic [31:0] RECIP25 = 32'h51EB851F;
	localparam int RECIP_SH = 35;

	typedef enum logic [1:0] {
		CFG_TOL  = 2'd0,
		CFG_FRAC = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic [LEN_W-1:0] old;
		logic             dev_zero;
		logic             gt1000;
		logic             gt100;
	} side_t;

endpackage

// File: rtl/chord_step_size_estimator_unit.sv
// ----------------------------------------------------------------------------
// chord_step_size_estimator_unit
// next trial step from previous step and its chord deviation
// ----------------------------------------------------------------------------
// throughput: one item per cycle once busy has dropped after reset; the
// 64-stage divider and 32-stage root pipelines each retire one bit per stage
// reset: pipeline emptied, registers back to 0.25 mm and 0.98, busy held
// high until the first clock after reset release
`include "chord_step_size_estimator_unit_macros.svh"

module chord_step_size_estimator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [csse_pkg::LEN_W-1:0]   step_old,
	input  logic [csse_pkg::LEN_W-1:0]   chord_dev,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [csse_pkg::LEN_W-1:0]   cfg_data,
	output logic                         done,
	output logic [csse_pkg::LEN_W-1:0]   step_next,
	output logic [csse_pkg::LEN_W-1:0]   free_estimate,
	output logic                         estimate_valid
);

	localparam int W = csse_pkg::LEN_W;

	logic [W-1:0]                  tol_q;
	logic [csse_pkg::FRAC_W-1:0]   frac_q;
	logic                          busy_q;
	logic                          accept;

	logic [41:0]     tol1000;
	logic [38:0]     tol100;
	csse_pkg::side_t side_in;

	logic            vld_s1;
	logic [W-1:0]    num_s1;
	logic [W-1:0]    dev_s1;
	csse_pkg::side_t side_s1;

	logic                       div_vld;
	logic [csse_pkg::Q_W-1:0]   quot;
	csse_pkg::side_t            div_side;
	logic                       sq_vld;
	logic [W-1:0]               root;
	csse_pkg::side_t            sq_side;

	assign busy      = busy_q;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			tol_q  <= csse_pkg::TOL_RESET;
			frac_q <= csse_pkg::FRAC_RESET;
		end else begin
			busy_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					csse_pkg::CFG_TOL:  tol_q  <= cfg_data;
					csse_pkg::CFG_FRAC: frac_q <= cfg_data[csse_pkg::FRAC_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// deviation against 1000x and 100x tolerance
	assign tol1000 = (42'(tol_q) << 10) - (42'(tol_q) << 4) - (42'(tol_q) << 3);
	assign tol100  = (39'(tol_q) << 6) + (39'(tol_q) << 5) + (39'(tol_q) << 2);

	always_comb begin
		side_in.old      = step_old;
		side_in.dev_zero = chord_dev == '0;
		side_in.gt1000   = 42'(chord_dev) > tol1000;
		side_in.gt100    = 39'(chord_dev) > tol100;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		num_s1  <= tol_q;
		dev_s1  <= chord_dev;
		side_s1 <= side_in;
	end

	csse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s1),
		.num      (num_s1),
		.dev      (dev_s1),
		.side_in  (side_s1),
		.out_vld  (div_vld),
		.quot     (quot),
		.side_out (div_side)
	);

	csse_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (div_vld),
		.rad      (quot),
		.side_in  (div_side),
		.out_vld  (sq_vld),
		.root     (root),
		.side_out (sq_side)
	);

	csse_post u_post (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_vld         (sq_vld),
		.root           (root),
		.side_in        (sq_side),
		.frac           (frac_q),
		.done           (done),
		.step_next      (step_next),
		.free_estimate  (free_estimate),
		.estimate_valid (estimate_valid)
	);

	`CSSE_ASSERT_NOW(a_done_from_beat, clk, arst_n, done, $past(accept, csse_pkg::PIPE_LAT))
	`CSSE_ASSERT_NOW(a_beat_gives_done, clk, arst_n, $past(accept, csse_pkg::PIPE_LAT), done)
	`CSSE_ASSERT_NOW(a_step_nonzero, clk, arst_n, done, step_next != '0)
	`CSSE_ASSERT_NOW(a_est_invalid_zero, clk, arst_n, done && !estimate_valid, free_estimate == '0)

endmodule

// File: rtl/csse_div.sv
// ----------------------------------------------------------------------------
// csse_div
// pipelined restoring divider: (tol << 32) / dev, one quotient bit per stage
// ----------------------------------------------------------------------------
module csse_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic [csse_pkg::LEN_W-1:0]   num,
	input  logic [csse_pkg::LEN_W-1:0]   dev,
	input  csse_pkg::side_t              side_in,
	output logic                         out_vld,
	output logic [csse_pkg::Q_W-1:0]     quot,
	output csse_pkg::side_t              side_out
);

	localparam int N = csse_pkg::DIV_STAGES;
	localparam int W = csse_pkg::LEN_W;

	logic                   vld_s  [0:N];
	logic [W-1:0]           rem_s  [0:N];
	logic [W-1:0]           num_s  [0:N];
	logic [W-1:0]           dev_s  [0:N];
	logic [csse_pkg::Q_W-1:0] quot_s [0:N];
	csse_pkg::side_t        side_s [0:N];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = '0;
	assign num_s[0]  = num;
	assign dev_s[0]  = dev;
	assign quot_s[0] = '0;
	assign side_s[0] = side_in;

	for (genvar g = 0; g < N; g++) begin : g_stage
		logic [W:0] part;
		logic       ge;

		// low half of the dividend is zero, shifted in once num runs empty
		assign part = {rem_s[g], num_s[g][W-1]};
		assign ge = part >= {1'b0, dev_s[g]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1]  <= ge ? W'(part - {1'b0, dev_s[g]}) : part[W-1:0];
			quot_s[g+1] <= {quot_s[g][csse_pkg::Q_W-2:0], ge};
			num_s[g+1]  <= {num_s[g][W-2:0], 1'b0};
			dev_s[g+1]  <= dev_s[g];
			side_s[g+1] <= side_s[g];
		end
	end

	assign out_vld  = vld_s[N];
	assign quot     = quot_s[N];
	assign side_out = side_s[N];

endmodule

// File: rtl/csse_sqrt.sv
// ----------------------------------------------------------------------------
// csse_sqrt
// pipelined digit-by-digit integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module csse_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic [csse_pkg::Q_W-1:0]     rad,
	input  csse_pkg::side_t              side_in,
	output logic                         out_vld,
	output logic [csse_pkg::LEN_W-1:0]   root,
	output csse_pkg::side_t              side_out
);

	localparam int N = csse_pkg::SQRT_STAGES;
	localparam int W = csse_pkg::LEN_W;
	localparam int QW = csse_pkg::Q_W;

	logic            vld_s  [0:N];
	logic [W:0]      rem_s  [0:N];
	logic [W-1:0]    root_s [0:N];
	logic [QW-1:0]   rad_s  [0:N];
	csse_pkg::side_t side_s [0:N];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = rad;
	assign side_s[0] = side_in;

	for (genvar g = 0; g < N; g++) begin : g_stage
		logic [W+2:0] part;
		logic [W+2:0] trial;
		logic         ge;

		assign part  = {rem_s[g], rad_s[g][QW-1:QW-2]};
		assign trial = (W+3)'({root_s[g], 2'b01});
		assign ge    = part >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		// remainder stays at most twice the root
		always_ff @(posedge clk) begin
			rem_s[g+1]  <= ge ? (W+1)'(part - trial) : part[W:0];
			root_s[g+1] <= {root_s[g][W-2:0], ge};
			rad_s[g+1]  <= {rad_s[g][QW-3:0], 2'b00};
			side_s[g+1] <= side_s[g];
		end
	end

	assign out_vld  = vld_s[N];
	assign root     = root_s[N];
	assign side_out = side_s[N];

endmodule

// File: rtl/csse_post.sv
// ----------------------------------------------------------------------------
// csse_post
// scaling multiplies, cut / clamp decision and saturation, four stages
// ----------------------------------------------------------------------------
module csse_post (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic [csse_pkg::LEN_W-1:0]   root,
	input  csse_pkg::side_t              side_in,
	input  logic [csse_pkg::FRAC_W-1:0]  frac,
	output logic                         done,
	output logic [csse_pkg::LEN_W-1:0]   step_next,
	output logic [csse_pkg::LEN_W-1:0]   free_estimate,
	output logic                         estimate_valid
);

	localparam int W = csse_pkg::LEN_W;
	localparam int EW = W + 16;

	// stage 1
	logic            vld_s1;
	csse_pkg::side_t side_s1;
	logic [63:0]     pest_s1;
	logic [63:0]     p10_s1;
	logic [63:0]     p25_s1;
	logic [W-1:0]    z3;

	// stage 2
	logic            vld_s2;
	csse_pkg::side_t side_s2;
	logic [63:0]     ptr_s2;
	logic [W-1:0]    cut10_s2;
	logic [W-1:0]    cut3_s2;
	logic [W-1:0]    est_s2;
	logic [EW-1:0]   est;

	// stage 3
	logic            vld_s3;
	logic [EW-1:0]   trial;
	logic [57:0]     trial1000;
	logic [41:0]     old1000;
	logic [EW-1:0]   trial_s3;
	logic [41:0]     old1000_s3;
	logic [W-1:0]    cut_s3;
	logic            small_s3;
	logic            big_s3;
	logic [W-1:0]    est_s3;
	logic            ev_s3;

	logic [EW-1:0]   pick;
	logic [W-1:0]    sat;

	// 3*old/100 = floor(floor(3*old/4) / 25)
	assign z3 = W'(((W+2)'(side_in.old) * (W+2)'(3)) >> 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done   <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= side_in;
		pest_s1 <= 64'(side_in.old) * 64'(root);
		p10_s1  <= 64'(side_in.old) * 64'(csse_pkg::RECIP10);
		p25_s1  <= 64'(z3) * 64'(csse_pkg::RECIP25);
	end

	assign est = pest_s1[63:16];

	always_ff @(posedge clk) begin
		side_s2  <= side_s1;
		ptr_s2   <= 64'(est) * 64'(frac);
		cut10_s2 <= W'(p10_s1 >> csse_pkg::RECIP_SH);
		cut3_s2  <= W'(p25_s1 >> csse_pkg::RECIP_SH);
		est_s2   <= (est > EW'({W{1'b1}})) ? {W{1'b1}} : est[W-1:0];
	end

	// zero deviation doubles the old step
	assign trial = side_s2.dev_zero ? EW'({side_s2.old, 1'b0}) : ptr_s2[63:16];
	assign trial1000 = (58'(trial) << 10) - (58'(trial) << 4) - (58'(trial) << 3);
	assign old1000 = (42'(side_s2.old) << 10) - (42'(side_s2.old) << 4)
		- (42'(side_s2.old) << 3);

	always_ff @(posedge clk) begin
		trial_s3   <= trial;
		old1000_s3 <= old1000;
		small_s3   <= trial1000 <= 58'(side_s2.old);
		big_s3     <= trial > EW'(old1000);
		cut_s3     <= side_s2.gt1000 ? cut3_s2 :
			side_s2.gt100 ? cut10_s2 : (side_s2.old >> 1);
		est_s3     <= side_s2.dev_zero ? '0 : est_s2;
		ev_s3      <= !side_s2.dev_zero;
	end

	always_comb begin
		if (small_s3) begin
			pick = EW'(cut_s3);
		end else if (big_s3) begin
			pick = EW'(old1000_s3);
		end else begin
			pick = trial_s3;
		end
		sat = (pick > EW'({W{1'b1}})) ? {W{1'b1}} : pick[W-1:0];
	end

	always_ff @(posedge clk) begin
		step_next      <= (sat == '0) ? W'(1) : sat;
		free_estimate  <= est_s3;
		estimate_valid <= ev_s3;
	end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the chord step size estimator: a directed table
// followed by random steps under several tolerance and fraction settings,
// each checked in order against its table result or a bit-exact predictor
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 5000;
	localparam int RAND_PER_PHASE = 270;
	localparam logic [csse_pkg::LEN_W-1:0] LEN_MAX = '1;

	typedef struct packed {
		logic [csse_pkg::LEN_W-1:0] step;
		logic [csse_pkg::LEN_W-1:0] estimate;
		logic                       valid;
	} step_res_t;

	typedef struct packed {
		logic [csse_pkg::LEN_W-1:0] old;
		logic [csse_pkg::LEN_W-1:0] dev;
		logic                       typed;
		step_res_t                  res;
	} row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [csse_pkg::LEN_W-1:0]    step_old;
	logic [csse_pkg::LEN_W-1:0]    chord_dev;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [1:0]                    cfg_index;
	logic [csse_pkg::LEN_W-1:0]    cfg_data;
	logic                          done;
	logic [csse_pkg::LEN_W-1:0]    step_next;
	logic [csse_pkg::LEN_W-1:0]    free_estimate;
	logic                          estimate_valid;

	logic [csse_pkg::LEN_W-1:0]    tol_shadow;
	logic [csse_pkg::FRAC_W-1:0]   frac_shadow;
	step_res_t                     pending_steps[$];
	int                            errors = 0;
	int                            stall_cycles = 0;
	int                            burst_left;

	chord_step_size_estimator_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.step_old(step_old), .chord_dev(chord_dev),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .step_next(step_next),
		.free_estimate(free_estimate), .estimate_valid(estimate_valid)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic logic [63:0] sqrt_floor(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] cand;
		res = 0;
		for (int i = 31; i >= 0; i--) begin
			cand = res | (64'd1 << i);
			if (cand * cand <= v)
				res = cand;
		end
		return res;
	endfunction

	function automatic step_res_t predict_step(logic [csse_pkg::LEN_W-1:0] old_in,
			logic [csse_pkg::LEN_W-1:0] dev_in);
		logic [63:0] o, d, tol, est, trial, ratio;
		step_res_t r;
		o = old_in;
		d = dev_in;
		tol = tol_shadow;
		est = 0;
		r.valid = 1'b0;
		if (d != 0) begin
			ratio = (tol << 32) / d;
			est = (o * sqrt_floor(ratio)) >> csse_pkg::FRAC_W;
			trial = (est * 64'(frac_shadow)) >> csse_pkg::FRAC_W;
			r.valid = 1'b1;
		end else begin
			trial = o * 2;
		end
		// collapsed trial: fall back to a fixed cut of the old step
		if (trial * 1000 <= o) begin
			if (d > 1000 * tol)
				trial = (o * 3) / 100;
			else if (d > 100 * tol)
				trial = o / 10;
			else
				trial = o >> 1;
		end else if (trial > 1000 * o) begin
			trial = 1000 * o;
		end
		if (trial > 64'(LEN_MAX))
			trial = 64'(LEN_MAX);
		if (trial == 0)
			trial = 1;
		r.step = trial[csse_pkg::LEN_W-1:0];
		if (!r.valid)
			r.estimate = '0;
		else if (est > 64'(LEN_MAX))
			r.estimate = LEN_MAX;
		else
			r.estimate = est[csse_pkg::LEN_W-1:0];
		return r;
	endfunction

	// result checking
	always @(posedge clk) begin
		step_res_t exp_r;
		if (arst_n && done) begin
			if (pending_steps.size() == 0) begin
				$display("%0t: unexpected result step %h est %h valid %b", $realtime,
					step_next, free_estimate, estimate_valid);
				errors++;
			end else begin
				exp_r = pending_steps.pop_front();
				if (step_next !== exp_r.step) begin
					$display("%0t: step_next expected %h actual %h", $realtime,
						exp_r.step, step_next);
					errors++;
				end
				if (free_estimate !== exp_r.estimate) begin
					$display("%0t: free_estimate expected %h actual %h", $realtime,
						exp_r.estimate, free_estimate);
					errors++;
				end
				if (estimate_valid !== exp_r.valid) begin
					$display("%0t: estimate_valid expected %b actual %b", $realtime,
						exp_r.valid, estimate_valid);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no beat anywhere
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [csse_pkg::LEN_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == csse_pkg::CFG_TOL)
			tol_shadow = data;
		else if (idx == csse_pkg::CFG_FRAC)
			frac_shadow = data[csse_pkg::FRAC_W-1:0];
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_steps.size() != 0)
			@(posedge clk);
		repeat (csse_pkg::PIPE_LAT + 4) @(posedge clk);
	endtask

	// one step beat; start stays high inside a burst
	task automatic send_step(logic [csse_pkg::LEN_W-1:0] o, logic [csse_pkg::LEN_W-1:0] d,
			logic typed, step_res_t typed_res);
		int gap;
		start <= 1'b1;
		step_old <= o;
		chord_dev <= d;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_steps.push_back(typed ? typed_res : predict_step(o, d));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 10);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic logic [csse_pkg::LEN_W-1:0] rand_len();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return LEN_MAX;
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	function automatic logic [csse_pkg::LEN_W-1:0] rand_dev();
		logic [63:0] d;
		case ($urandom_range(0, 9)) inside
			0: return '0;
			[1:2]: return $urandom;
			[3:6]: begin
				// land near the tolerance multiples that pick the cut
				d = (64'(tol_shadow) * $urandom_range(0, 1200)) >> $urandom_range(0, 3);
				d = d + $urandom_range(0, 2) - 1;
				if (d > 64'(LEN_MAX))
					return $urandom;
				return d[csse_pkg::LEN_W-1:0];
			end
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	task automatic run_random(int n);
		for (int i = 0; i < n; i++)
			send_step(rand_len(), rand_dev(), 1'b0, '0);
		start <= 1'b0;
	endtask

	row_t table_rows[] = '{
		// 1 mm at exactly the tolerance: estimate = old, trial = 0.98 of it
		'{32'h0001_0000, 32'h0000_4000, 1'b1, '{32'd64225, 32'h0001_0000, 1'b1}},
		// zero deviation doubles the step
		'{32'h0001_0000, 32'h0000_0000, 1'b1, '{32'h0002_0000, 32'h0, 1'b0}},
		'{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0001, 32'h0, 1'b0}},
		'{LEN_MAX,       32'h0000_0000, 1'b1, '{LEN_MAX, 32'h0, 1'b0}},
		'{32'h0000_0000, 32'h0000_4000, 1'b1, '{32'h0000_0001, 32'h0, 1'b1}},
		'{LEN_MAX,       32'h0000_0001, 1'b0, '0},
		'{LEN_MAX,       LEN_MAX,       1'b0, '0},
		'{32'h0000_0001, LEN_MAX,       1'b0, '0},
		'{32'h0000_0001, 32'h0000_0001, 1'b0, '0},
		'{32'h0001_0000, 32'h003E_8001, 1'b0, '0},
		'{32'h0001_0000, 32'h003E_8000, 1'b0, '0},
		'{32'h0001_0000, 32'h0006_4001, 1'b0, '0},
		'{32'h0001_0000, 32'h0006_4000, 1'b0, '0},
		'{32'h0123_4567, 32'h0006_4001, 1'b0, '0},
		'{32'hFFFF_0000, 32'h0000_0100, 1'b0, '0},
		'{32'h0000_FFFF, 32'hFFFF_0000, 1'b0, '0},
		'{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
		'{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0}
	};

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		step_old = '0;
		chord_dev = '0;
		cfg_valid = 1'b0;
		cfg_index = csse_pkg::CFG_TOL;
		cfg_data = '0;
		burst_left = 0;
		tol_shadow = csse_pkg::TOL_RESET;
		frac_shadow = csse_pkg::FRAC_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i])
			send_step(table_rows[i].old, table_rows[i].dev, table_rows[i].typed,
				table_rows[i].res);
		run_random(RAND_PER_PHASE);

		// extremes, with upper bits on the fraction write masked off
		drain();
		write_reg(csse_pkg::CFG_TOL, 32'h0000_0001);
		write_reg(csse_pkg::CFG_FRAC, 32'hABCD_FFFF);
		write_reg(CFG_UNUSED, 32'h1234_5678);
		run_random(RAND_PER_PHASE);

		drain();
		write_reg(csse_pkg::CFG_TOL, LEN_MAX);
		write_reg(csse_pkg::CFG_FRAC, 32'h0000_0001);
		run_random(RAND_PER_PHASE);

		// out of range settings push every nonzero-deviation step into the cut rule
		drain();
		write_reg(csse_pkg::CFG_TOL, 32'h0000_0000);
		write_reg(csse_pkg::CFG_FRAC, 32'h0000_0000);
		run_random(RAND_PER_PHASE / 2);

		drain();
		write_reg(csse_pkg::CFG_TOL, $urandom_range(1, 32'h0010_0000));
		write_reg(csse_pkg::CFG_FRAC, $urandom_range(1, 65535));
		run_random(RAND_PER_PHASE);

		while (pending_steps.size() != 0)
			@(posedge clk);
		repeat (csse_pkg::PIPE_LAT + 10) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
